// File: src/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
`default_nettype none
package sem_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
  localparam int CFG_DATA_W = 11;

  // Input item kinds.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_PAD   = 1'b1;

  localparam int PIX_W = 24;
  localparam int SUM_W = 22;
  localparam logic [SUM_W-1:0] ROOT_TOP_BIT = 22'h100000;
  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_last;
  } out_item_t;

  // One pending gradient job: border-masked 3x3 window, index col*3 + row.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  last;
  } job_t;

  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ROOT,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// File: src/sem_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output      logic [WIDTH-1:0]           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: src/sem_front.sv
// Front end: accepts pixels, keeps line memory, window and position, and issues gradient jobs.
`default_nettype none
module sem_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire sem_pkg::in_item_t                in_item,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data,
  output      logic                             q_push,
  output      sem_pkg::job_t                    q_job,
  input  wire logic                             q_full
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int PW = sem_pkg::PIX_W;

  sem_pkg::front_state_t state_r, state_nxt;
  sem_pkg::in_item_t     item_r;
  logic [AW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [WW-1:0]         width_r;
  logic [HW-1:0]         height_r;
  logic [8:0][PW-1:0]    win_r, win_nxt;
  logic                  accept, adv;
  logic [2*PW-1:0]       rdata, wdata;
  logic [PW-1:0]         up, mid, v;
  logic [WW-1:0]         wm1, cinc;
  logic [HW-1:0]         hm1;
  logic [AW-1:0]         wlast, cc;
  logic [RW-1:0]         hlast, cr;
  logic                  c_ge1, pos_ok, job_valid, last;

  function automatic logic [WW-1:0] clamp_w(logic [sem_pkg::CFG_DATA_W-1:0] d);
    logic [31:0] e;
    e = 32'(d);
    if (e == 32'd0) e = 32'd1;
    else if (e > 32'(MAX_WIDTH)) e = 32'(MAX_WIDTH);
    return WW'(e);
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [sem_pkg::CFG_DATA_W-1:0] d);
    logic [31:0] e;
    e = 32'(d);
    if (e == 32'd0) e = 32'd1;
    else if (e > 32'(MAX_HEIGHT)) e = 32'(MAX_HEIGHT);
    return HW'(e);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != sem_pkg::FR_IDLE);
  assign accept    = in_valid && !in_stall;

  sem_ram #(.WIDTH(2 * PW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (adv),
    .waddr (col_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (rdata)
  );

  always_comb begin
    up    = rdata[2*PW-1:PW];
    mid   = rdata[PW-1:0];
    wm1   = width_r - WW'(1);
    hm1   = height_r - HW'(1);
    wlast = wm1[AW-1:0];
    hlast = RW'(hm1);
    c_ge1 = (col_r != '0);
    pos_ok = c_ge1 ? (row_r >= RW'(1)) : (row_r >= RW'(2));
    cr    = c_ge1 ? (row_r - RW'(1)) : (row_r - RW'(2));
    cc    = c_ge1 ? (col_r - AW'(1)) : wlast;
    job_valid = pos_ok && (cr < RW'(height_r));
    last  = job_valid && (cr == hlast) && (cc == wlast);
    if ((row_r < RW'(height_r)) && (item_r.action == sem_pkg::ACT_PIXEL)) begin
      v = {item_r.pixel_red, item_r.pixel_green, item_r.pixel_blue};
    end else begin
      v = '0;
    end
    wdata = {mid, v};
    for (int k = 0; k < 6; k++) begin
      win_nxt[k] = win_r[k+3];
    end
    win_nxt[6] = up;
    win_nxt[7] = mid;
    win_nxt[8] = v;
    for (int k = 0; k < 9; k++) begin
      if (((k / 3 == 0) && (cc == '0)) || ((k / 3 == 2) && (cc == wlast)) ||
          ((k % 3 == 0) && (cr == '0)) || ((k % 3 == 2) && (cr == hlast))) begin
        q_job.win[k] = '0;
      end else begin
        q_job.win[k] = win_nxt[k];
      end
    end
    q_job.last = last;
    cinc = WW'(col_r) + WW'(1);
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cinc >= width_r) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = cinc[AW-1:0];
      row_nxt = row_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    adv       = 1'b0;
    case (state_r)
      sem_pkg::FR_IDLE: begin
        if (accept) state_nxt = sem_pkg::FR_UPDATE;
      end
      sem_pkg::FR_UPDATE: begin
        if (!q_full) begin
          adv       = 1'b1;
          state_nxt = sem_pkg::FR_IDLE;
        end
      end
      default: state_nxt = sem_pkg::FR_IDLE;
    endcase
    q_push = adv && job_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sem_pkg::FR_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
      win_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        win_r <= win_nxt;
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sem_pkg::CFG_FRAME_WIDTH) begin
          width_r <= clamp_w(cfg_data);
          col_r   <= '0;
          row_r   <= '0;
        end else if (cfg_index == sem_pkg::CFG_FRAME_HEIGHT) begin
          height_r <= clamp_h(cfg_data);
          col_r    <= '0;
          row_r    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
  end

`ifndef SYNTHESIS
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job pushed into a full queue");
`endif
endmodule
`default_nettype wire

// File: src/sem_queue.sv
// Two-entry job queue between the front end and the gradient back end.
`default_nettype none
module sem_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sem_pkg::job_t push_job,
  output      logic          full,
  input  wire logic          pop,
  output      sem_pkg::job_t head,
  output      logic          empty
);
  sem_pkg::job_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job queue popped while empty");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !full) |=> !empty) else $error("job queue lost a push");
`endif
endmodule
`default_nettype wire

// File: src/sem_back.sv
// Back end: Sobel gradients, sum of squares and iterative rounded root per channel.
`default_nettype none
module sem_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire sem_pkg::job_t q_head,
  output      logic          q_pop,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      sem_pkg::out_item_t out_item
);
  localparam int SW = sem_pkg::SUM_W;

  sem_pkg::back_state_t state_r, state_nxt;
  logic signed [10:0] gx_r [3];
  logic signed [10:0] gy_r [3];
  logic [SW-1:0]      rem_r [3];
  logic [SW-1:0]      n_r [3];
  logic [SW-1:0]      bit_r;
  logic               last_r;
  logic               out_valid_r;
  sem_pkg::out_item_t out_r;
  logic               load;
  logic signed [10:0] gx [3];
  logic signed [10:0] gy [3];
  logic [7:0]         res [3];

  function automatic logic [7:0] chan(logic [sem_pkg::PIX_W-1:0] p, int ch);
    return p[16-8*ch +: 8];
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = (11'(chan(q_head.win[6], ch)) + (11'(chan(q_head.win[7], ch)) << 1)
              + 11'(chan(q_head.win[8], ch)))
             - (11'(chan(q_head.win[0], ch)) + (11'(chan(q_head.win[1], ch)) << 1)
              + 11'(chan(q_head.win[2], ch)));
      gy[ch] = (11'(chan(q_head.win[2], ch)) + (11'(chan(q_head.win[5], ch)) << 1)
              + 11'(chan(q_head.win[8], ch)))
             - (11'(chan(q_head.win[0], ch)) + (11'(chan(q_head.win[3], ch)) << 1)
              + 11'(chan(q_head.win[6], ch)));
      if (rem_r[ch] > n_r[ch]) begin
        res[ch] = (n_r[ch] >= SW'(sem_pkg::SAT_MAX)) ? sem_pkg::SAT_MAX
                                                      : n_r[ch][7:0] + 8'd1;
      end else begin
        res[ch] = (n_r[ch] > SW'(sem_pkg::SAT_MAX)) ? sem_pkg::SAT_MAX : n_r[ch][7:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    case (state_r)
      sem_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = sem_pkg::BK_SQUARE;
        end
      end
      sem_pkg::BK_SQUARE: state_nxt = sem_pkg::BK_ROOT;
      sem_pkg::BK_ROOT: begin
        if (bit_r == SW'(1)) state_nxt = sem_pkg::BK_EMIT;
      end
      sem_pkg::BK_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = sem_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sem_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sem_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      sem_pkg::BK_IDLE: begin
        for (int ch = 0; ch < 3; ch++) begin
          gx_r[ch] <= gx[ch];
          gy_r[ch] <= gy[ch];
        end
        last_r <= q_head.last;
      end
      sem_pkg::BK_SQUARE: begin
        for (int ch = 0; ch < 3; ch++) begin
          rem_r[ch] <= SW'(gx_r[ch] * gx_r[ch]) + SW'(gy_r[ch] * gy_r[ch]);
          n_r[ch]   <= '0;
        end
        bit_r <= sem_pkg::ROOT_TOP_BIT;
      end
      sem_pkg::BK_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (rem_r[ch] >= n_r[ch] + bit_r) begin
            rem_r[ch] <= rem_r[ch] - (n_r[ch] + bit_r);
            n_r[ch]   <= (n_r[ch] >> 1) + bit_r;
          end else begin
            n_r[ch] <= n_r[ch] >> 1;
          end
        end
        bit_r <= bit_r >> 2;
      end
      default: begin
      end
    endcase
    if (load) begin
      out_r.edge_red   <= res[0];
      out_r.edge_green <= res[1];
      out_r.edge_blue  <= res[2];
      out_r.frame_last <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sem_pkg::BK_ROOT) |-> $onehot(bit_r))
    else $error("root step bit is not a single power of four");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r) else $error("loaded result not presented");
`endif
endmodule
`default_nettype wire

// File: src/sobel_edge_magnitude_rgb_top.sv
// Top level of the RGB Sobel edge magnitude block.
// The front end takes a transaction, reads the line memory, then writes it back and advances;
// it stalls input until that update is done, which waits while the job queue is full. Each
// result passes the back-end steps in order: gradient, squares, 11 root steps, output load.
// The back end pops no new job until it has loaded the last result; its root unit sets the rate.
// Reset (rst_n low, synchronous) clears counters, window, queue and state; line memory is not
// cleared, since border masking never lets unwritten entries reach a result.
`default_nettype none
module sobel_edge_magnitude_rgb_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire sem_pkg::in_item_t                in_item,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      sem_pkg::out_item_t               out_item,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data
);
  // Jobs flow from the front end into a two-entry queue. Each job carries the
  // border-masked 3x3 window of one output pixel plus its end-of-frame flag,
  // so the back end needs no knowledge of image position.
  logic          q_push, q_full, q_pop, q_empty;
  sem_pkg::job_t q_job, q_head;

  // The front end owns the line memory, the window and the position counters.
  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_job     (q_job),
    .q_full    (q_full)
  );

  // The queue lets the front end keep taking transactions while the root unit works.
  sem_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // The back end computes the three channel magnitudes and holds the output register.
  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire
